@@ sv/bcu_pkg.sv @@
// Shared types and constants for the branch call-trick unfilter unit.
package bcu_pkg;

    localparam int WINDOW = 8;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int POS_W  = 32;

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_E8,
        MODE_E9,
        MODE_E8E9,
        MODE_JCC,
        MODE_ARM_LE,
        MODE_ARM_BE,
        MODE_ARM64
    } mode_t;

    typedef enum logic {
        REG_FILTER_MODE,
        REG_MARKER_BYTE
    } cfg_idx_t;

    localparam logic [7:0] OP_CALL      = 8'he8;
    localparam logic [7:0] OP_JMP       = 8'he9;
    localparam logic [7:0] OP_ESC       = 8'h0f;
    localparam logic [3:0] OP_JCC_HI    = 4'h8;
    localparam logic [7:0] ARM_BL_MASK  = 8'h0f;
    localparam logic [7:0] ARM_BL_CODE  = 8'h0b;
    localparam logic [7:0] A64_B_MASK   = 8'h7c;
    localparam logic [7:0] A64_B_CODE   = 8'h14;

    localparam int X86_SPAN = 6;
    localparam int ARM_SPAN = 5;

endpackage

@@ sv/branch_calltrick_unfilter_unit.sv @@
// Branch call-trick unfilter: restores relative branch operands in a byte stream.
//
// Bytes go in and come out one word per cycle, in order, with out_last on the final
// byte of each buffer. The sustained rate is one byte per clock in each direction.
// Bytes sit in an eight-entry look-ahead window: a byte that may open a branch (x86
// opcode, or an aligned ARM word) is held until five (x86) or four (ARM) following
// bytes of its buffer have arrived, or the buffer ends, and output bytes are then
// registered. in_stall rises only when the window is full, which happens only while
// the output side stalls. Bytes of the next buffer may follow the last byte of a
// buffer without a gap.
module branch_calltrick_unfilter_unit
    import bcu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    mode_t              filter_mode_reg;
    logic [7:0]         marker_reg;

    logic [7:0]         win_reg  [WINDOW];
    logic               wlast_reg[WINDOW];
    logic [7:0]         win_next [WINDOW];
    logic               wlast_next[WINDOW];
    logic [7:0]         conv     [WINDOW];

    logic [FILL_W-1:0]  fill_reg,  fill_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [2:0]         skip_reg,  skip_next;
    logic [7:0]         prev_reg,  prev_next;
    logic               jao_reg,   jao_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic               accept, pop, head_ready;
    logic               is_x86, is_arm, br, end_x86, end_arm;
    logic               conv_x86, conv_arm;
    logic [FILL_W-1:0]  wr_idx;
    logic [31:0]        pos32, idx32, x86_v;
    logic [23:0]        arm_v;
    logic [25:0]        a64_v;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= MODE_NONE;
            marker_reg      <= 8'h00;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_FILTER_MODE: filter_mode_reg <= mode_t'(cfg_data[2:0]);
                REG_MARKER_BYTE: marker_reg      <= cfg_data;
                default:         marker_reg      <= marker_reg;
            endcase
        end
    end

    assign is_x86 = (filter_mode_reg == MODE_E8) || (filter_mode_reg == MODE_E9) ||
                    (filter_mode_reg == MODE_E8E9) || (filter_mode_reg == MODE_JCC);
    assign is_arm = (filter_mode_reg == MODE_ARM_LE) || (filter_mode_reg == MODE_ARM_BE) ||
                    (filter_mode_reg == MODE_ARM64);

    // Buffer end seen within the span a candidate needs
    always_comb
    begin
        end_x86 = 1'b0;
        end_arm = 1'b0;
        for (int i = 0; i < X86_SPAN - 1; i++)
        begin
            if ((FILL_W'(i) < fill_reg) && wlast_reg[i])
                end_x86 = 1'b1;
        end
        for (int i = 0; i < ARM_SPAN - 1; i++)
        begin
            if ((FILL_W'(i) < fill_reg) && wlast_reg[i])
                end_arm = 1'b1;
        end
    end

    assign br = ((filter_mode_reg != MODE_E9) && (win_reg[0] == OP_CALL)) ||
                ((filter_mode_reg != MODE_E8) && (win_reg[0] == OP_JMP)) ||
                ((filter_mode_reg == MODE_JCC) && (pos_reg != '0) && !jao_reg &&
                 (prev_reg == OP_ESC) && (win_reg[0][7:4] == OP_JCC_HI));

    assign pos32 = 32'(pos_reg);
    assign idx32 = pos32 >> 2;
    // marker<<24 cancels the top operand byte, leaving {w2,w3,w4} - pos - 1
    assign x86_v = {8'h00, win_reg[2], win_reg[3], win_reg[4]} + ~pos32;
    assign arm_v = (filter_mode_reg == MODE_ARM_LE)
                 ? ({win_reg[2], win_reg[1], win_reg[0]} - idx32[23:0])
                 : ({win_reg[1], win_reg[2], win_reg[3]} - idx32[23:0]);
    assign a64_v = {win_reg[3][1:0], win_reg[2], win_reg[1], win_reg[0]} - idx32[25:0];

    always_comb
    begin
        head_ready = 1'b1;
        conv_x86   = 1'b0;
        conv_arm   = 1'b0;
        if (is_x86)
        begin
            if ((skip_reg == 3'd0) && br)
            begin
                head_ready = (fill_reg >= FILL_W'(X86_SPAN)) || end_x86;
                conv_x86   = (fill_reg >= FILL_W'(X86_SPAN)) && !end_x86 &&
                             (win_reg[1] == marker_reg);
            end
        end
        else if (is_arm)
        begin
            if (pos_reg[1:0] == 2'b00)
            begin
                head_ready = (fill_reg >= FILL_W'(ARM_SPAN)) || end_arm;
                case (filter_mode_reg)
                    MODE_ARM_LE: conv_arm = ((win_reg[3] & ARM_BL_MASK) == ARM_BL_CODE);
                    MODE_ARM_BE: conv_arm = ((win_reg[0] & ARM_BL_MASK) == ARM_BL_CODE);
                    default:     conv_arm = ((win_reg[3] & A64_B_MASK) == A64_B_CODE);
                endcase
                conv_arm = conv_arm && (fill_reg >= FILL_W'(ARM_SPAN)) && !end_arm;
            end
        end
    end

    // Window contents with any operand rewrite applied
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
            conv[i] = win_reg[i];
        if (conv_x86)
        begin
            conv[1] = x86_v[7:0];
            conv[2] = x86_v[15:8];
            conv[3] = x86_v[23:16];
            conv[4] = x86_v[31:24];
        end
        else if (conv_arm)
        begin
            case (filter_mode_reg)
                MODE_ARM_LE:
                begin
                    conv[0] = arm_v[7:0];
                    conv[1] = arm_v[15:8];
                    conv[2] = arm_v[23:16];
                end
                MODE_ARM_BE:
                begin
                    conv[1] = arm_v[23:16];
                    conv[2] = arm_v[15:8];
                    conv[3] = arm_v[7:0];
                end
                default:
                begin
                    conv[0] = a64_v[7:0];
                    conv[1] = a64_v[15:8];
                    conv[2] = a64_v[23:16];
                    conv[3] = {win_reg[3][7:2], a64_v[25:24]};
                end
            endcase
        end
    end

    assign in_stall = (fill_reg == FILL_W'(WINDOW));
    assign accept   = in_valid && !in_stall;
    assign pop      = (fill_reg != '0) && head_ready && (!out_valid_reg || !out_stall);
    assign wr_idx   = fill_reg - FILL_W'(pop);

    always_comb
    begin
        for (int i = 0; i < WINDOW - 1; i++)
        begin
            win_next[i]   = pop ? conv[i + 1]      : win_reg[i];
            wlast_next[i] = pop ? wlast_reg[i + 1] : wlast_reg[i];
        end
        win_next[WINDOW-1]   = win_reg[WINDOW-1];
        wlast_next[WINDOW-1] = wlast_reg[WINDOW-1];
        for (int i = 0; i < WINDOW; i++)
        begin
            if (accept && (wr_idx == FILL_W'(i)))
            begin
                win_next[i]   = data_byte;
                wlast_next[i] = last_byte;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg + FILL_W'(accept) - FILL_W'(pop);
        pos_next  = pos_reg;
        skip_next = skip_reg;
        prev_next = prev_reg;
        jao_next  = jao_reg;
        if (pop)
        begin
            if (wlast_reg[0])
            begin
                pos_next  = '0;
                skip_next = 3'd0;
                prev_next = 8'h00;
                jao_next  = 1'b0;
            end
            else
            begin
                pos_next  = pos_reg + POS_W'(1);
                prev_next = conv[0];
                if (skip_reg != 3'd0)
                begin
                    skip_next = skip_reg - 3'd1;
                    jao_next  = (skip_reg == 3'd1);
                end
                else
                begin
                    skip_next = conv_x86 ? 3'd4 : 3'd0;
                    jao_next  = 1'b0;
                end
            end
        end
    end

    assign out_valid_next = pop || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pos_reg       <= '0;
            skip_reg      <= 3'd0;
            prev_reg      <= 8'h00;
            jao_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            prev_reg      <= prev_next;
            jao_reg       <= jao_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Window and output words carry no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            win_reg[i]   <= win_next[i];
            wlast_reg[i] <= wlast_next[i];
        end
        if (pop)
        begin
            out_byte_reg <= conv[0];
            out_last_reg <= wlast_reg[0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("window fill beyond capacity");

    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= 3'd4)
        else $error("operand skip count out of range");

    a_buf_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && wlast_reg[0]) |=> (pos_reg == '0) && (skip_reg == 3'd0))
        else $error("stream state not cleared at buffer end");

    a_x86_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && conv_x86) |=> (skip_reg == 3'd4) || (pos_reg == '0))
        else $error("converted operand not skipped");

endmodule
